// ===== design/ffba_pkg.sv =====
// shared constants, codes and types of the first-fit block allocator
package ffba_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int OFFSET_BITS_DEF  = 24;

  localparam int ADDR_BITS      = 32;
  localparam int SIZE_BITS      = 24;
  localparam int STATUS_BITS    = 3;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [ADDR_BITS-1:0] ARENA_BASE_RESET = 32'hC040_0000;
  localparam logic [ADDR_BITS-1:0] HEAP_LIMIT_RESET = 32'hC100_0000;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ARENA_BASE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEAP_LIMIT = 1'b1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_BITS-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_ZERO_REQ  = 3'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 3'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_EXHAUSTED = 3'd3;
  localparam logic [STATUS_BITS-1:0] STATUS_UNMATCHED = 3'd4;

  typedef struct packed {
    logic                 is_free;
    logic [ADDR_BITS-1:0] key;
    logic [SIZE_BITS-1:0] req;
  } scan_ctrl_t;

endpackage

// ===== design/first_fit_block_allocator_unit.sv =====
// top level of the first-fit block allocator: sequencer, state and result register
//
// Input channel (in_valid/in_ready) carries cmd, request_size and free_address.
// An allocate scans the block table from entry 0 for the first free block whose
// size covers the request; with no fit a new block is appended at the top pointer.
// A free scans for the entry whose payload address equals free_address.
// Output channel (out_valid/out_ready) returns payload_address, status and reused,
// exactly one result transaction per input transaction.
// The table sits in one ram with registered read; the scan reads and tests one
// entry per cycle. An accepted transaction passes setup, scan, update (apply or
// append) and result (finish); a zero-byte allocate goes from setup straight to
// result, and a free with no match or an allocate into a full table skips the
// update. The sequencer returns to idle before the next acceptance.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register while the next transaction is accepted, and the sequencer
// holds its result until that register is free when the receiver stalls.
// Reset (rst, synchronous) empties the table, rewinds the top pointer, drops any
// pending result and restores the arena base and heap_limit; no clearing pass.
// cfg_we/cfg_index/cfg_data write the arena base (0) and heap_limit (1); the user
// must write them only while idle, as the block itself does not enforce it.
module first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int OFFSET_BITS  = ffba_pkg::OFFSET_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ffba_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ffba_pkg::ADDR_BITS-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic [ffba_pkg::SIZE_BITS-1:0]        request_size,
  input  logic [ffba_pkg::ADDR_BITS-1:0]        free_address,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ffba_pkg::ADDR_BITS-1:0]        payload_address,
  output logic [ffba_pkg::STATUS_BITS-1:0]      status,
  output logic                                  reused
);

  localparam int AW  = ffba_pkg::ADDR_BITS;
  localparam int ZW  = ffba_pkg::SIZE_BITS;
  localparam int IW  = $clog2(MAX_BLOCKS);
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int WW  = OFFSET_BITS + ZW + 1;
  localparam int TW  = OFFSET_BITS + 1;
  localparam int NTW = ((TW > ZW + 1) ? TW : ZW + 1) + 1;
  localparam int SW  = ((NTW > AW) ? NTW : AW) + 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_APPLY  = 6'b001000,
    S_APPEND = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic [AW-1:0]          arena_base;
  logic [AW-1:0]          heap_limit;
  logic [CW-1:0]          block_count;
  logic [TW-1:0]          top_offset;

  logic                   cmd_q;
  logic [ZW-1:0]          req_q;
  logic [AW-1:0]          addr_q;
  logic [AW-1:0]          key;
  logic [NTW-1:0]         new_top;

  logic [CW-1:0]          rd_idx;
  logic                   pv;
  logic [IW-1:0]          cmp_idx;
  logic [IW-1:0]          hit_idx;
  logic [OFFSET_BITS-1:0] hit_start;
  logic [ZW-1:0]          hit_size;

  logic [AW-1:0]          res_addr;
  logic [2:0]             res_status;
  logic                   res_reused;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [WW-1:0]          ram_wdata;
  logic [WW-1:0]          ram_rdata;

  logic [OFFSET_BITS-1:0] ent_start;
  logic [ZW-1:0]          ent_size;
  logic                   ent_free;
  logic                   hit;
  logic                   issue;
  logic                   is_last;
  logic [SW-1:0]          end_addr;
  logic                   exhausted;
  logic [AW-1:0]          append_addr;

  ffba_pkg::scan_ctrl_t   ctrl;

  assign ctrl.is_free = (cmd_q == ffba_pkg::CMD_FREE);
  assign ctrl.key     = key;
  assign ctrl.req     = req_q;

  assign ent_start = ram_rdata[WW-1 -: OFFSET_BITS];
  assign ent_size  = ram_rdata[ZW:1];
  assign ent_free  = ram_rdata[0];

  assign issue       = (rd_idx < block_count);
  assign is_last     = ((CW'(hit_idx) + CW'(1)) == block_count);
  assign end_addr    = SW'(arena_base) + SW'(new_top);
  assign exhausted   = (end_addr > SW'(heap_limit)) ||
                       (new_top > (NTW'(1) << OFFSET_BITS));
  assign append_addr = arena_base + AW'(top_offset[OFFSET_BITS-1:0]) + AW'(HEADER_BYTES);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx;
    ram_wdata = {hit_start, hit_size, ctrl.is_free};
    if (state == S_APPLY) begin
      ram_we = 1'b1;
    end else if (state == S_APPEND && !exhausted) begin
      ram_we    = 1'b1;
      ram_waddr = block_count[IW-1:0];
      ram_wdata = {top_offset[OFFSET_BITS-1:0], req_q, 1'b0};
    end
  end

  ffba_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  ffba_match #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_match (
    .ctrl        (ctrl),
    .entry_start (ent_start),
    .entry_size  (ent_size),
    .entry_free  (ent_free),
    .hit         (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      arena_base  <= ffba_pkg::ARENA_BASE_RESET;
      heap_limit  <= ffba_pkg::HEAP_LIMIT_RESET;
      block_count <= '0;
      top_offset  <= '0;
      out_valid   <= 1'b0;
      pv          <= 1'b0;
      rd_idx      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ffba_pkg::CFG_ARENA_BASE: arena_base <= cfg_data;
          ffba_pkg::CFG_HEAP_LIMIT: heap_limit <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q  <= cmd;
            req_q  <= request_size;
            addr_q <= free_address;
            state  <= S_SETUP;
          end
        end
        S_SETUP: begin
          key     <= addr_q - arena_base - AW'(HEADER_BYTES);
          new_top <= NTW'(top_offset) + NTW'(HEADER_BYTES) + NTW'(req_q);
          rd_idx  <= '0;
          pv      <= 1'b0;
          if (cmd_q == ffba_pkg::CMD_ALLOC && req_q == '0) begin
            res_addr   <= '0;
            res_status <= ffba_pkg::STATUS_ZERO_REQ;
            res_reused <= 1'b0;
            state      <= S_FINISH;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pv      <= issue;
          cmp_idx <= rd_idx[IW-1:0];
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (pv && hit) begin
            hit_idx   <= cmp_idx;
            hit_start <= ent_start;
            hit_size  <= ent_size;
            state     <= S_APPLY;
          end else if (!pv && !issue) begin
            res_addr   <= '0;
            res_reused <= 1'b0;
            if (ctrl.is_free) begin
              res_status <= ffba_pkg::STATUS_UNMATCHED;
              state      <= S_FINISH;
            end else if (block_count == CW'(MAX_BLOCKS)) begin
              res_status <= ffba_pkg::STATUS_FULL;
              state      <= S_FINISH;
            end else begin
              state <= S_APPEND;
            end
          end
        end
        S_APPLY: begin
          res_status <= ffba_pkg::STATUS_OK;
          if (ctrl.is_free) begin
            res_addr   <= '0;
            res_reused <= 1'b0;
            if (is_last) begin
              top_offset  <= TW'(hit_start);
              block_count <= CW'(hit_idx);
            end
          end else begin
            res_addr   <= arena_base + AW'(hit_start) + AW'(HEADER_BYTES);
            res_reused <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_APPEND: begin
          res_reused <= 1'b0;
          if (exhausted) begin
            res_addr   <= '0;
            res_status <= ffba_pkg::STATUS_EXHAUSTED;
          end else begin
            res_addr    <= append_addr;
            res_status  <= ffba_pkg::STATUS_OK;
            block_count <= block_count + CW'(1);
            top_offset  <= new_top[TW-1:0];
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            payload_address <= res_addr;
            status          <= res_status;
            reused          <= res_reused;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/ffba_ram.sv =====
// generic single-write, single-read ram with registered read data
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ffba_match.sv =====
// shared compare unit: tests one table entry against the current request
module ffba_match #(
  parameter int OFFSET_BITS = ffba_pkg::OFFSET_BITS_DEF
) (
  input  ffba_pkg::scan_ctrl_t              ctrl,
  input  logic [OFFSET_BITS-1:0]            entry_start,
  input  logic [ffba_pkg::SIZE_BITS-1:0]    entry_size,
  input  logic                              entry_free,
  output logic                              hit
);

  localparam int AW = ffba_pkg::ADDR_BITS;

  always_comb begin
    if (ctrl.is_free) begin
      hit = (AW'(entry_start) == ctrl.key);
    end else begin
      hit = entry_free && (entry_size >= ctrl.req);
    end
  end

endmodule
